### hw/rtl/typed_frame_crc16_checker_assert.svh
// Assertion macros for the typed frame CRC-16 checker.
`ifndef TYPED_FRAME_CRC16_CHECKER_ASSERT_SVH
`define TYPED_FRAME_CRC16_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
// Condition implies consequence in the same cycle.
`define TFC_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("checker assertion failed");
// Condition implies consequence in the next cycle.
`define TFC_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("checker assertion failed");
`else
`define TFC_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons)
`define TFC_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)
`endif

`endif

### hw/rtl/tfc_pkg.sv
// Types, constants and the byte-wide CRC step shared by the frame checker.
package tfc_pkg;

	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [15:0] SEED_DEFAULT = 16'hDCBD;

	localparam logic [7:0] KIND_T1 = 8'h01;
	localparam logic [7:0] KIND_T2 = 8'h02;
	localparam logic [7:0] KIND_T3 = 8'h03;
	localparam logic [7:0] KIND_T4 = 8'h04;
	localparam logic [7:0] KIND_T5 = 8'h05;

	localparam logic [8:0] LEN_T1 = 9'd13;
	localparam logic [8:0] LEN_T2 = 9'd17;
	localparam logic [8:0] LEN_T4 = 9'd19;
	localparam logic [8:0] LEN_T5 = 9'd29;
	localparam logic [8:0] LEN_VAR_EXTRA = 9'd4;

	typedef enum logic [1:0] {
		STATUS_GOOD     = 2'd0,
		STATUS_MISMATCH = 2'd1,
		STATUS_UNKNOWN  = 2'd2
	} tfc_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} tfc_in_t;

	typedef struct packed {
		tfc_status_t status;
		logic [7:0]  kind;
		logic [8:0]  total_length;
	} tfc_result_t;

	typedef struct packed {
		logic       in_frame;
		logic [8:0] byte_index;
	} tfc_core_status_t;

	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} tfc_buf_status_t;

	// One byte through CRC-16/CCITT, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Fixed frame length per type; zero for the variable-length type and unknown types.
	function automatic logic [8:0] kind_length(input logic [7:0] kind);
		logic [8:0] len;
		case (kind)
			KIND_T1: len = LEN_T1;
			KIND_T2: len = LEN_T2;
			KIND_T4: len = LEN_T4;
			KIND_T5: len = LEN_T5;
			default: len = 9'd0;
		endcase
		return len;
	endfunction

endpackage

### hw/rtl/typed_frame_crc16_checker.sv
// Top level of the typed frame CRC-16 checker.
//
// Receives a frame one byte per transfer and checks its trailing big-endian
// CRC-16/CCITT (polynomial 0x1021, MSB first, no final XOR) against the CRC
// of every byte but the last two, started from the programmable initial CRC
// register. The type byte marked by frame_start fixes the frame length, or for
// the variable-length type the second byte does; an unknown type gives status
// 2 at once. The block takes one byte every cycle while byte_stall is low: the
// byte-wide CRC step sits between the frame state registers, and the one
// status result of a frame is registered in the output buffer after its final
// byte. The byte channel stalls only while two results wait in the output
// buffer. A write of the initial CRC takes effect at the next frame start.
`include "typed_frame_crc16_checker_assert.svh"

module typed_frame_crc16_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  tfc_pkg::tfc_in_t     byte_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output tfc_pkg::tfc_result_t result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);
	import tfc_pkg::*;

	logic [15:0]      init_crc_q;
	logic             accept;
	logic             res_valid;
	tfc_result_t      res;
	tfc_core_status_t core_st;
	tfc_buf_status_t  buf_st;
	logic             start_accept;
	logic             type_known;
	logic             frame_opened;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_crc_q <= SEED_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			init_crc_q <= cfg_data;
		end
	end

	assign accept = byte_valid && !byte_stall;

	tfc_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (byte_data),
		.seed     (init_crc_q),
		.res_valid(res_valid),
		.res      (res),
		.st       (core_st)
	);

	tfc_out_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.full     (byte_stall),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_data (result_data),
		.st       (buf_st)
	);

	assign start_accept = accept && byte_data.frame_start;
	assign type_known   = byte_data.data_byte inside {[KIND_T1:KIND_T5]};
	assign frame_opened = core_st.in_frame && (core_st.byte_index == 9'd1);

	// A waiting skid entry always sits behind an occupied output register.
	`TFC_ASSERT_IMPL(a_skid_behind_main, clk, arst_n, buf_st.skid_valid, buf_st.main_valid)

	// A start byte of an unknown type yields a result on the next cycle.
	`TFC_ASSERT_NEXT(a_unknown_reports, clk, arst_n, start_accept && !type_known, result_valid)

	// A start byte of a known type opens a frame positioned after the type byte.
	`TFC_ASSERT_NEXT(a_known_opens, clk, arst_n, start_accept && type_known, frame_opened)

endmodule

### hw/rtl/tfc_frame_core.sv
// Frame tracking state and per-byte CRC update; flags the byte that ends a frame.
module tfc_frame_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  tfc_pkg::tfc_in_t          item,
	input  logic [15:0]               seed,
	output logic                      res_valid,
	output tfc_pkg::tfc_result_t      res,
	output tfc_pkg::tfc_core_status_t st
);
	import tfc_pkg::*;

	logic [15:0] crc_q;
	logic [8:0]  byte_index_q;
	logic [8:0]  exp_len_q;
	logic [7:0]  kind_q;
	logic [7:0]  crc_hi_q;
	logic        in_frame_q;

	logic        known;
	logic [15:0] crc_in;
	logic [15:0] crc_fed;
	logic [8:0]  exp_eff;
	logic [9:0]  idx_p2;
	logic        do_feed;
	logic        do_high;
	logic [15:0] received;

	always_comb begin
		known    = item.data_byte inside {[KIND_T1:KIND_T5]};
		crc_in   = item.frame_start ? seed : crc_q;
		crc_fed  = crc16_byte(crc_in, item.data_byte);
		// The variable-length type takes its length from the second byte.
		if (byte_index_q == 9'd1 && kind_q == KIND_T3) begin
			exp_eff = {1'b0, item.data_byte} + LEN_VAR_EXTRA;
		end else begin
			exp_eff = exp_len_q;
		end
		idx_p2   = {1'b0, byte_index_q} + 10'd2;
		do_feed  = (byte_index_q < 9'd2) || (idx_p2 < {1'b0, exp_eff});
		do_high  = (idx_p2 == {1'b0, exp_eff});
		received = {crc_hi_q, item.data_byte};
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '{status: STATUS_UNKNOWN, kind: item.data_byte, total_length: 9'd0};
		if (accept) begin
			if (item.frame_start) begin
				res_valid = !known;
			end else if (in_frame_q && !do_feed && !do_high) begin
				res_valid = 1'b1;
				res.status = (received == crc_q) ? STATUS_GOOD : STATUS_MISMATCH;
				res.kind = kind_q;
				res.total_length = exp_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			byte_index_q <= 9'd0;
		end else if (accept) begin
			if (item.frame_start) begin
				in_frame_q   <= known;
				byte_index_q <= known ? 9'd1 : 9'd0;
			end else if (in_frame_q) begin
				if (do_feed || do_high) begin
					byte_index_q <= byte_index_q + 9'd1;
				end else begin
					in_frame_q   <= 1'b0;
					byte_index_q <= 9'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (item.frame_start) begin
				kind_q    <= item.data_byte;
				crc_hi_q  <= 8'h00;
				exp_len_q <= kind_length(item.data_byte);
				crc_q     <= known ? crc_fed : seed;
			end else if (in_frame_q) begin
				exp_len_q <= exp_eff;
				if (do_feed) begin
					crc_q <= crc_fed;
				end else if (do_high) begin
					crc_hi_q <= item.data_byte;
				end
			end
		end
	end

	assign st = '{in_frame: in_frame_q, byte_index: byte_index_q};

endmodule

### hw/rtl/tfc_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
module tfc_out_buf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  tfc_pkg::tfc_result_t     push_data,
	output logic                     full,
	output logic                     out_valid,
	input  logic                     out_stall,
	output tfc_pkg::tfc_result_t     out_data,
	output tfc_pkg::tfc_buf_status_t st
);
	import tfc_pkg::*;

	tfc_result_t main_q;
	tfc_result_t skid_q;
	logic        main_valid_q;
	logic        skid_valid_q;
	logic        pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// Input is stalled while the skid entry is occupied, so no push here.
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign st        = '{main_valid: main_valid_q, skid_valid: skid_valid_q};

endmodule
